/* rtl/near_black_logo_classifier_macros.svh */
// Assertion macros shared by the classifier RTL.
`ifndef NEAR_BLACK_LOGO_CLASSIFIER_MACROS_SVH
`define NEAR_BLACK_LOGO_CLASSIFIER_MACROS_SVH
`ifndef SYNTH
`define NBLC_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);
`define NBLC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NBLC_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define NBLC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

/* rtl/nblc_pkg.sv */
// Shared types and constants of the near-black classifier.
package nblc_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_FLOOR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LUMA_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHROMA_LIMIT = 3'd4;

    localparam logic [7:0] RST_IMAGE_WIDTH  = 8'd40;
    localparam logic [7:0] RST_IMAGE_HEIGHT = 8'd40;
    localparam logic [7:0] RST_ALPHA_FLOOR  = 8'd40;
    localparam logic [7:0] RST_LUMA_LIMIT   = 8'd50;
    localparam logic [7:0] RST_CHROMA_LIMIT = 8'd28;

    localparam logic [7:0] LUMA_R_COEF = 8'd77;
    localparam logic [7:0] LUMA_G_COEF = 8'd150;
    localparam logic [7:0] LUMA_B_COEF = 8'd29;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int QUOT_W = 8;
    localparam int QBIT_W = $clog2(QUOT_W);

    typedef struct packed {
        logic [7:0] image_width;
        logic [7:0] image_height;
        logic [7:0] alpha_floor;
        logic [7:0] luma_limit;
        logic [7:0] chroma_limit;
    } cfg_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } back_state_t;

endpackage

/* rtl/nblc_if.sv */
// Pixel and result channel interfaces.
interface nblc_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;

    modport source (output valid, output blue, output green, output red, output alpha,
                    input ready);
    modport sink   (input valid, input blue, input green, input red, input alpha,
                    output ready);
endinterface

interface nblc_result_if;
    logic       valid;
    logic       ready;
    logic       near_black;
    logic       has_opaque;
    logic [7:0] mean_luma;
    logic [7:0] mean_chroma;

    modport source (output valid, output near_black, output has_opaque,
                    output mean_luma, output mean_chroma, input ready);
    modport sink   (input valid, input near_black, input has_opaque,
                    input mean_luma, input mean_chroma, output ready);
endinterface

/* rtl/nblc_front.sv */
// Front end: pixel intake, grid sampling, weighted accumulation, job hand-off.
`include "near_black_logo_classifier_macros.svh"

module nblc_front #(
    parameter int MAX_SIDE   = 128,
    parameter int GRID_CELLS = 32,
    parameter int ASW        = 22,
    parameter int LSW        = 30
) (
    input  logic                         clk,
    input  logic                         rst_n,
    nblc_pixel_if.sink                   pix,
    input  nblc_pkg::cfg_t               cfg,
    input  logic                         cfg_wr,
    input  logic [nblc_pkg::QCNT_W-1:0]  q_count,
    output logic                         job_push,
    output logic [LSW-1:0]               job_luma,
    output logic [LSW-1:0]               job_chroma,
    output logic [ASW-1:0]               job_alpha
);
    import nblc_pkg::*;

    localparam int PW       = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SW       = $clog2(MAX_SIDE + 1);
    localparam int CMPW     = (SW > 8) ? SW : 8;
    localparam int MAX_STEP = (MAX_SIDE + GRID_CELLS - 1) / GRID_CELLS;
    localparam int STW      = $clog2(MAX_STEP + 1);
    localparam int PHW      = (MAX_STEP > 1) ? $clog2(MAX_STEP) : 1;
    localparam int NW       = $clog2(MAX_SIDE + GRID_CELLS);
    localparam int GL       = $clog2(GRID_CELLS);
    localparam int RK       = NW + GL;
    localparam int RW       = RK + 1;
    localparam longint unsigned RECIP =
        ((longint'(1) << RK) + longint'(GRID_CELLS) - 1) / longint'(GRID_CELLS);
    localparam logic [RW-1:0] RECIP_V = RW'(RECIP);
    localparam int RCW      = $clog2(PW + 2);
    localparam logic [RCW-1:0] RS_LOAD = RCW'(PW + 1);

    function automatic logic [SW-1:0] clamp_side(input logic [7:0] s);
        logic [CMPW-1:0] se;
        se = CMPW'(s);
        if (se == '0)
            return SW'(1);
        else if (se > CMPW'(MAX_SIDE))
            return SW'(MAX_SIDE);
        else
            return SW'(se);
    endfunction

    function automatic logic [STW-1:0] grid_step(input logic [SW-1:0] side);
        logic [NW-1:0]    n;
        logic [NW+RW-1:0] p;
        n = NW'(side) + NW'(GRID_CELLS - 1);
        p = (NW + RW)'(n) * (NW + RW)'(RECIP_V);
        return STW'(p >> RK);
    endfunction

    function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        logic [7:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic logic [7:0] min3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        logic [7:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    // position and phase
    logic [PW-1:0]  col_reg, row_reg;
    logic [PHW-1:0] col_ph_reg, row_ph_reg;
    logic [STW-1:0] step_w_reg, step_h_reg;

    // phase resync after a register write
    logic           rs_busy_reg;
    logic [RCW-1:0] rs_cnt_reg;
    logic [PW-1:0]  col_sh_reg, row_sh_reg;
    logic [STW-1:0] col_rem_reg, row_rem_reg;

    // pipeline
    logic           s1_valid_reg, s1_last_reg;
    logic [7:0]     s1_luma_reg, s1_chroma_reg, s1_alpha_reg;
    logic           s2_valid_reg, s2_last_reg;
    logic [15:0]    s2_lp_reg, s2_cp_reg;
    logic [7:0]     s2_alpha_reg;

    logic [LSW-1:0] luma_sum_reg, chroma_sum_reg;
    logic [ASW-1:0] alpha_sum_reg;

    logic [SW-1:0]  w_eff, h_eff;
    logic [PW-1:0]  w_last, h_last;
    logic           row_end, img_last, sampled, accept;
    logic [15:0]    luma_full;
    logic [QCNT_W:0] in_flight;
    logic [STW:0]   col_rem2, row_rem2;
    logic [STW-1:0] col_rem_new, row_rem_new;
    logic [LSW-1:0] luma_sum_next, chroma_sum_next;
    logic [ASW-1:0] alpha_sum_next;

    assign w_eff    = clamp_side(cfg.image_width);
    assign h_eff    = clamp_side(cfg.image_height);
    assign w_last   = PW'(w_eff - SW'(1));
    assign h_last   = PW'(h_eff - SW'(1));
    assign row_end  = (col_reg >= w_last);
    assign img_last = row_end && (row_reg >= h_last);
    assign sampled  = (col_ph_reg == '0) && (row_ph_reg == '0) && (pix.alpha >= cfg.alpha_floor);

    // hold intake during a grid realignment and while the queue could not take every image end already in flight
    assign in_flight = (QCNT_W + 1)'(q_count)
                     + (QCNT_W + 1)'(s1_valid_reg && s1_last_reg)
                     + (QCNT_W + 1)'(s2_valid_reg && s2_last_reg);
    assign pix.ready = !rs_busy_reg && (in_flight < (QCNT_W + 1)'(QUEUE_DEPTH));
    assign accept    = pix.valid && pix.ready;

    assign luma_full = 16'(LUMA_R_COEF) * 16'(pix.red)
                     + 16'(LUMA_G_COEF) * 16'(pix.green)
                     + 16'(LUMA_B_COEF) * 16'(pix.blue);

    assign col_rem2    = {col_rem_reg, col_sh_reg[PW-1]};
    assign row_rem2    = {row_rem_reg, row_sh_reg[PW-1]};
    assign col_rem_new = (col_rem2 >= {1'b0, step_w_reg}) ?
                         STW'(col_rem2 - {1'b0, step_w_reg}) : STW'(col_rem2);
    assign row_rem_new = (row_rem2 >= {1'b0, step_h_reg}) ?
                         STW'(row_rem2 - {1'b0, step_h_reg}) : STW'(row_rem2);

    // grid step per axis, registered from the configuration registers
    always_ff @(posedge clk)
    begin
        step_w_reg <= grid_step(w_eff);
        step_h_reg <= grid_step(h_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_busy_reg <= 1'b1;
            rs_cnt_reg  <= RS_LOAD;
            col_sh_reg  <= '0;
            row_sh_reg  <= '0;
            col_rem_reg <= '0;
            row_rem_reg <= '0;
        end
        else if (cfg_wr)
        begin
            rs_busy_reg <= 1'b1;
            rs_cnt_reg  <= RS_LOAD;
        end
        else if (rs_busy_reg)
        begin
            rs_cnt_reg <= rs_cnt_reg - RCW'(1);
            if (rs_cnt_reg == RS_LOAD)
            begin
                col_sh_reg  <= col_reg;
                row_sh_reg  <= row_reg;
                col_rem_reg <= '0;
                row_rem_reg <= '0;
            end
            else
            begin
                col_sh_reg  <= col_sh_reg << 1;
                row_sh_reg  <= row_sh_reg << 1;
                col_rem_reg <= col_rem_new;
                row_rem_reg <= row_rem_new;
                if (rs_cnt_reg == RCW'(1))
                    rs_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            col_ph_reg <= '0;
            row_ph_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                if (img_last)
                begin
                    col_reg <= '0;
                    row_reg <= '0;
                end
                else if (row_end)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + PW'(1);
                end
                else
                begin
                    col_reg <= col_reg + PW'(1);
                end
            end

            if (rs_busy_reg && !cfg_wr && rs_cnt_reg == RCW'(1))
            begin
                col_ph_reg <= PHW'(col_rem_new);
                row_ph_reg <= PHW'(row_rem_new);
            end
            else if (accept)
            begin
                if (row_end || STW'(col_ph_reg) == step_w_reg - STW'(1))
                    col_ph_reg <= '0;
                else
                    col_ph_reg <= col_ph_reg + PHW'(1);

                if (img_last)
                    row_ph_reg <= '0;
                else if (row_end)
                begin
                    if (STW'(row_ph_reg) == step_h_reg - STW'(1))
                        row_ph_reg <= '0;
                    else
                        row_ph_reg <= row_ph_reg + PHW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s1_last_reg  <= accept && img_last;
            s2_valid_reg <= s1_valid_reg;
            s2_last_reg  <= s1_valid_reg && s1_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_luma_reg   <= luma_full[15:8];
        s1_chroma_reg <= max3(pix.red, pix.green, pix.blue) - min3(pix.red, pix.green, pix.blue);
        s1_alpha_reg  <= sampled ? pix.alpha : 8'd0;
        s2_lp_reg     <= 16'(s1_luma_reg) * 16'(s1_alpha_reg);
        s2_cp_reg     <= 16'(s1_chroma_reg) * 16'(s1_alpha_reg);
        s2_alpha_reg  <= s1_alpha_reg;
    end

    assign luma_sum_next   = luma_sum_reg + LSW'(s2_lp_reg);
    assign chroma_sum_next = chroma_sum_reg + LSW'(s2_cp_reg);
    assign alpha_sum_next  = alpha_sum_reg + ASW'(s2_alpha_reg);

    // drop the sums once the image's last pixel has been folded in
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            luma_sum_reg   <= '0;
            chroma_sum_reg <= '0;
            alpha_sum_reg  <= '0;
        end
        else if (s2_valid_reg)
        begin
            if (s2_last_reg)
            begin
                luma_sum_reg   <= '0;
                chroma_sum_reg <= '0;
                alpha_sum_reg  <= '0;
            end
            else
            begin
                luma_sum_reg   <= luma_sum_next;
                chroma_sum_reg <= chroma_sum_next;
                alpha_sum_reg  <= alpha_sum_next;
            end
        end
    end

    assign job_push   = s2_valid_reg && s2_last_reg;
    assign job_luma   = luma_sum_next;
    assign job_chroma = chroma_sum_next;
    assign job_alpha  = alpha_sum_next;

    `NBLC_ASSERT_IMP(a_col_phase_in_step, clk, rst_n, !rs_busy_reg,
        STW'(col_ph_reg) < step_w_reg, "column phase outside grid step")
    `NBLC_ASSERT_IMP(a_row_phase_in_step, clk, rst_n, !rs_busy_reg,
        STW'(row_ph_reg) < step_h_reg, "row phase outside grid step")

endmodule

/* rtl/nblc_queue.sv */
// Short job queue between the front end and the divider.
`include "near_black_logo_classifier_macros.svh"

module nblc_queue #(
    parameter int DW = 82
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [DW-1:0]                push_data,
    input  logic                         pop,
    output logic [DW-1:0]                pop_data,
    output logic [nblc_pkg::QCNT_W-1:0]  count
);
    import nblc_pkg::*;

    logic [DW-1:0]     mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

    assign pop_data = mem_reg[rd_ptr_reg];
    assign count    = count_reg;

    `NBLC_ASSERT_IMP(a_no_overflow, clk, rst_n, push,
        count_reg != QCNT_W'(QUEUE_DEPTH) || pop, "job queue overflow")
    `NBLC_ASSERT_IMP(a_no_underflow, clk, rst_n, pop,
        count_reg != '0, "job queue underflow")

endmodule

/* rtl/nblc_back.sv */
// Back end: bit-serial mean division, classification and result register.
`include "near_black_logo_classifier_macros.svh"

module nblc_back #(
    parameter int ASW = 22,
    parameter int LSW = 30
) (
    input  logic            clk,
    input  logic            rst_n,
    input  nblc_pkg::cfg_t  cfg,
    input  logic            job_avail,
    input  logic [LSW-1:0]  job_luma,
    input  logic [LSW-1:0]  job_chroma,
    input  logic [ASW-1:0]  job_alpha,
    output logic            job_pop,
    nblc_result_if.source   res
);
    import nblc_pkg::*;

    back_state_t state_reg, state_next;

    logic [LSW-1:0]    lrem_reg, crem_reg, div_reg;
    logic [QUOT_W-1:0] lq_reg, cq_reg;
    logic [QBIT_W-1:0] bit_reg;
    logic              has_reg;
    logic              out_valid_reg;
    logic              out_nb_reg, out_has_reg;
    logic [7:0]        out_luma_reg, out_chroma_reg;

    logic              load, iterate, finish;
    logic              l_ge, c_ge;
    logic [7:0]        mean_l, mean_c;

    assign l_ge   = (lrem_reg >= div_reg);
    assign c_ge   = (crem_reg >= div_reg);
    assign mean_l = has_reg ? lq_reg : 8'd0;
    assign mean_c = has_reg ? cq_reg : 8'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        load       = 1'b0;
        iterate    = 1'b0;
        finish     = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (job_avail)
                begin
                    load       = 1'b1;
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                iterate = 1'b1;
                if (bit_reg == '0)
                    state_next = BK_DONE;
            end
            BK_DONE:
            begin
                // wait for the result register to free up
                if (!out_valid_reg || res.ready)
                begin
                    finish     = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign job_pop = load;

    // quotient is at most 255, so eight restoring steps against alpha << 7 .. alpha << 0
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lrem_reg <= job_luma;
            crem_reg <= job_chroma;
            div_reg  <= LSW'(job_alpha) << (QUOT_W - 1);
            lq_reg   <= '0;
            cq_reg   <= '0;
            bit_reg  <= QBIT_W'(QUOT_W - 1);
            has_reg  <= (job_alpha != '0);
        end
        else if (iterate)
        begin
            if (l_ge)
                lrem_reg <= lrem_reg - div_reg;
            if (c_ge)
                crem_reg <= crem_reg - div_reg;
            lq_reg  <= {lq_reg[QUOT_W-2:0], l_ge};
            cq_reg  <= {cq_reg[QUOT_W-2:0], c_ge};
            div_reg <= div_reg >> 1;
            bit_reg <= bit_reg - QBIT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (finish)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_has_reg    <= has_reg;
            out_luma_reg   <= mean_l;
            out_chroma_reg <= mean_c;
            out_nb_reg     <= has_reg && (mean_l < cfg.luma_limit) && (mean_c < cfg.chroma_limit);
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.near_black  = out_nb_reg;
    assign res.has_opaque  = out_has_reg;
    assign res.mean_luma   = out_luma_reg;
    assign res.mean_chroma = out_chroma_reg;

    `NBLC_ASSERT_IMP(a_empty_result_is_zero, clk, rst_n, out_valid_reg && !out_has_reg,
        !out_nb_reg && out_luma_reg == 8'd0 && out_chroma_reg == 8'd0,
        "result without opaque samples is not cleared")

endmodule

/* rtl/near_black_logo_classifier.sv */
// Near-black classifier top level: configuration registers and unit wiring.
//
// Pixels arrive on pix as BGRA words in raster order, one word per cycle at
// most; a pixel is taken when pix.valid and pix.ready are both high. The
// image's last pixel causes one word on res (near_black, has_opaque,
// mean_luma, mean_chroma), taken when res.valid and res.ready are high.
// Configuration goes through cfg_we / cfg_index / cfg_data, one register per
// cycle; any register write realigns the sampling grid with pix.ready low.
// Throughput: one pixel per cycle while pix.ready is high. The result word
// follows the last pixel taken through the second pipeline stage and the
// queue write, then one load, eight steps of the bit-serial divider and the
// output register. A queue of four finished images decouples the pixel side
// from the divider, which takes a new image only once the last is finished.
// After reset all registers hold their defaults, position and sums are zero,
// and pix.ready stays low while the sampling grid is realigned. While res is
// stalled the output register holds its word; the divider and then the queue
// fill, and outside a grid realignment pix.ready drops only when the queue
// could not take every image end in flight.
module near_black_logo_classifier #(
    parameter int MAX_SIDE   = 128,
    parameter int GRID_CELLS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    nblc_pixel_if.sink                     pix,
    nblc_result_if.source                  res,
    input  logic                           cfg_we,
    input  logic [nblc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data
);
    import nblc_pkg::*;

    localparam longint unsigned MAX_ALPHA_SUM = longint'(MAX_SIDE) * longint'(MAX_SIDE) * 255;
    localparam int ASW = $clog2(MAX_ALPHA_SUM + 1);
    localparam int LSW = ASW + 8;
    localparam int JW  = 2 * LSW + ASW;

    cfg_t cfg_reg;

    logic              job_push, job_pop;
    logic [LSW-1:0]    f_luma, f_chroma, b_luma, b_chroma;
    logic [ASW-1:0]    f_alpha, b_alpha;
    logic [JW-1:0]     q_out;
    logic [QCNT_W-1:0] q_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= RST_IMAGE_WIDTH;
            cfg_reg.image_height <= RST_IMAGE_HEIGHT;
            cfg_reg.alpha_floor  <= RST_ALPHA_FLOOR;
            cfg_reg.luma_limit   <= RST_LUMA_LIMIT;
            cfg_reg.chroma_limit <= RST_CHROMA_LIMIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_data;
                REG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_data;
                REG_ALPHA_FLOOR:  cfg_reg.alpha_floor  <= cfg_data;
                REG_LUMA_LIMIT:   cfg_reg.luma_limit   <= cfg_data;
                REG_CHROMA_LIMIT: cfg_reg.chroma_limit <= cfg_data;
                default:          ;
            endcase
        end
    end

    nblc_front #(
        .MAX_SIDE   (MAX_SIDE),
        .GRID_CELLS (GRID_CELLS),
        .ASW        (ASW),
        .LSW        (LSW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix        (pix),
        .cfg        (cfg_reg),
        .cfg_wr     (cfg_we),
        .q_count    (q_count),
        .job_push   (job_push),
        .job_luma   (f_luma),
        .job_chroma (f_chroma),
        .job_alpha  (f_alpha)
    );

    nblc_queue #(
        .DW (JW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data ({f_luma, f_chroma, f_alpha}),
        .pop       (job_pop),
        .pop_data  (q_out),
        .count     (q_count)
    );

    assign b_luma   = q_out[JW-1 -: LSW];
    assign b_chroma = q_out[ASW +: LSW];
    assign b_alpha  = q_out[ASW-1:0];

    nblc_back #(
        .ASW (ASW),
        .LSW (LSW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .job_avail  (q_count != '0),
        .job_luma   (b_luma),
        .job_chroma (b_chroma),
        .job_alpha  (b_alpha),
        .job_pop    (job_pop),
        .res        (res)
    );

endmodule

/* dv/tb_near_black_logo_classifier.sv */
`timescale 1ns / 100ps
// Testbench of the near-black classifier: scoreboard class, pixel driver, result monitor.
module tb_near_black_logo_classifier;
    import nblc_pkg::*;

    localparam int          MAX_SIDE      = 128;
    localparam int          GRID_CELLS    = 32;
    localparam int          ITEM_TARGET   = 1800;
    localparam int          QUIET_AFTER   = 1600;
    localparam int          SETTLE_CYCLES = 24;
    localparam int          LONG_HOLD     = 300;
    localparam int unsigned CYCLE_LIMIT   = 600000;

    typedef struct packed {
        logic       near_black;
        logic       has_opaque;
        logic [7:0] mean_luma;
        logic [7:0] mean_chroma;
    } verdict_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
    } pixel_t;

    typedef enum {PAINT_DARK, PAINT_NOISE, PAINT_FAINT} paint_t;

    class frame_verdicts;
        cfg_t            regs;
        int unsigned     col;
        int unsigned     row;
        longint unsigned luma_acc;
        longint unsigned chroma_acc;
        longint unsigned alpha_acc;
        verdict_t        due[$];
        int              errors;
        int              pixels;
        int              frames;
        int              dark_frames;
        int              empty_frames;

        function new();
            regs.image_width  = RST_IMAGE_WIDTH;
            regs.image_height = RST_IMAGE_HEIGHT;
            regs.alpha_floor  = RST_ALPHA_FLOOR;
            regs.luma_limit   = RST_LUMA_LIMIT;
            regs.chroma_limit = RST_CHROMA_LIMIT;
            col = 0;
            row = 0;
            luma_acc = 0;
            chroma_acc = 0;
            alpha_acc = 0;
            errors = 0;
            pixels = 0;
            frames = 0;
            dark_frames = 0;
            empty_frames = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
            case (idx)
                REG_IMAGE_WIDTH:  regs.image_width  = data;
                REG_IMAGE_HEIGHT: regs.image_height = data;
                REG_ALPHA_FLOOR:  regs.alpha_floor  = data;
                REG_LUMA_LIMIT:   regs.luma_limit   = data;
                REG_CHROMA_LIMIT: regs.chroma_limit = data;
                default: ;
            endcase
        endfunction

        function int unsigned side(logic [7:0] value);
            if (value == 0)
                return 1;
            if (value > MAX_SIDE)
                return MAX_SIDE;
            return value;
        endfunction

        // Account one accepted pixel; return 1 when it closes the image.
        function bit note_pixel(pixel_t p);
            int unsigned     w;
            int unsigned     h;
            int unsigned     step_x;
            int unsigned     step_y;
            int unsigned     rr;
            int unsigned     gg;
            int unsigned     bb;
            int unsigned     aa;
            int unsigned     lum;
            int unsigned     hi;
            int unsigned     lo;
            longint unsigned ml;
            longint unsigned mc;
            bit              row_end;
            bit              last;
            verdict_t        v;
            w = side(regs.image_width);
            h = side(regs.image_height);
            step_x = (w + GRID_CELLS - 1) / GRID_CELLS;
            step_y = (h + GRID_CELLS - 1) / GRID_CELLS;
            rr = p.red;
            gg = p.green;
            bb = p.blue;
            aa = p.alpha;
            row_end = col >= w - 1;
            last = row_end && row >= h - 1;
            pixels++;
            if (col % step_x == 0 && row % step_y == 0 && aa >= regs.alpha_floor)
            begin
                lum = (LUMA_R_COEF * rr + LUMA_G_COEF * gg + LUMA_B_COEF * bb) >> 8;
                hi = rr > gg ? rr : gg;
                hi = hi > bb ? hi : bb;
                lo = rr < gg ? rr : gg;
                lo = lo < bb ? lo : bb;
                luma_acc += lum * aa;
                chroma_acc += (hi - lo) * aa;
                alpha_acc += aa;
            end
            if (!last)
            begin
                if (row_end)
                begin
                    col = 0;
                    row++;
                end
                else
                    col++;
                return 0;
            end
            v = '0;
            if (alpha_acc != 0)
            begin
                ml = luma_acc / alpha_acc;
                mc = chroma_acc / alpha_acc;
                v.has_opaque  = 1'b1;
                v.mean_luma   = ml[7:0];
                v.mean_chroma = mc[7:0];
                v.near_black  = (ml < regs.luma_limit) && (mc < regs.chroma_limit);
            end
            due.insert(due.size(), v);
            frames++;
            if (v.near_black)
                dark_frames++;
            if (!v.has_opaque)
                empty_frames++;
            col = 0;
            row = 0;
            luma_acc = 0;
            chroma_acc = 0;
            alpha_acc = 0;
            return 1;
        endfunction

        function void check_result(verdict_t got);
            verdict_t want;
            if (due.size() == 0)
            begin
                $error("result word with no image pending");
                errors++;
                return;
            end
            want = due.pop_front();
            if (got.near_black !== want.near_black)
            begin
                $error("near_black: expected %0d, actual %0d", want.near_black, got.near_black);
                errors++;
            end
            if (got.has_opaque !== want.has_opaque)
            begin
                $error("has_opaque: expected %0d, actual %0d", want.has_opaque, got.has_opaque);
                errors++;
            end
            if (got.mean_luma !== want.mean_luma)
            begin
                $error("mean_luma: expected %0d, actual %0d", want.mean_luma, got.mean_luma);
                errors++;
            end
            if (got.mean_chroma !== want.mean_chroma)
            begin
                $error("mean_chroma: expected %0d, actual %0d",
                       want.mean_chroma, got.mean_chroma);
                errors++;
            end
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    nblc_pixel_if  pix_ch ();
    nblc_result_if res_ch ();

    frame_verdicts board;
    int            pix_gap_pct;
    int            res_gap_pct;
    bit            hold_request;
    int            settings_used;
    int unsigned   cycles;

    near_black_logo_classifier #(
        .MAX_SIDE   (MAX_SIDE),
        .GRID_CELLS (GRID_CELLS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Result side: take words, stall in bursts, honor one long hold-off.
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
                board.check_result(verdict_t'{res_ch.near_black, res_ch.has_opaque,
                                              res_ch.mean_luma, res_ch.mean_chroma});
            if (hold_request)
            begin
                hold_request = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                res_ch.ready <= 1'b1;
            end
            else if (res_gap_pct != 0 && $urandom_range(0, 99) < res_gap_pct)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                res_ch.ready <= 1'b1;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    task automatic write_config(input logic [7:0] w, input logic [7:0] h,
                                input logic [7:0] floor_v, input logic [7:0] luma_v,
                                input logic [7:0] chroma_v);
        logic [CFG_IDX_W-1:0] idx[5] = '{REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT,
                                         REG_ALPHA_FLOOR, REG_LUMA_LIMIT,
                                         REG_CHROMA_LIMIT};
        logic [7:0]           vals[5];
        vals = '{w, h, floor_v, luma_v, chroma_v};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            board.set_reg(idx[i], vals[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic send_pixel(input pixel_t p, output bit ended);
        if (pix_gap_pct != 0 && $urandom_range(0, 99) < pix_gap_pct)
        begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.blue  <= p.blue;
        pix_ch.green <= p.green;
        pix_ch.red   <= p.red;
        pix_ch.alpha <= p.alpha;
        do
            @(posedge clk);
        while (!pix_ch.ready);
        ended = board.note_pixel(p);
    endtask

    // Drop valid and hold until every pending verdict is in and the pipeline is empty.
    task automatic settle();
        pix_ch.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic pixel_t make_pixel(paint_t paint);
        pixel_t      p;
        int unsigned base;
        int unsigned spread;
        p = pixel_t'($urandom);
        case (paint)
            PAINT_DARK:
            begin
                base   = $urandom_range(0, 60);
                spread = $urandom_range(0, 30);
                p.blue  = 8'(base + $urandom_range(0, spread));
                p.green = 8'(base + $urandom_range(0, spread));
                p.red   = 8'(base + $urandom_range(0, spread));
                p.alpha = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                       : 8'($urandom_range(180, 255));
            end
            PAINT_FAINT: p.alpha = 8'($urandom_range(0, 60));
            default: ;
        endcase
        return p;
    endfunction

    task automatic send_frame(input paint_t paint);
        bit     ended;
        pixel_t p;
        ended = 1'b0;
        while (!ended)
        begin
            p = make_pixel(paint);
            if (paint == PAINT_DARK && $urandom_range(0, 9) == 0)
                p = make_pixel(PAINT_NOISE);
            send_pixel(p, ended);
        end
    endtask

    function automatic logic [7:0] pick_side();
        case ($urandom_range(0, 19))
            0:       return 8'd0;
            1:       return 8'($urandom_range(MAX_SIDE + 1, 255));
            2, 3:    return 8'($urandom_range(33, 80));
            default: return 8'($urandom_range(1, 10));
        endcase
    endfunction

    function automatic logic [7:0] pick_limit(int unsigned lo, int unsigned hi);
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(lo, hi));
        endcase
    endfunction

    task automatic random_phase();
        logic [7:0] w;
        logic [7:0] h;
        logic [7:0] tmp;
        int         roll;
        w = pick_side();
        h = pick_side();
        if (board.side(w) * board.side(h) > 160)
            h = 8'($urandom_range(0, 1));
        if ($urandom_range(0, 1))
        begin
            tmp = w;
            w = h;
            h = tmp;
        end
        write_config(w, h, pick_limit(0, 120), pick_limit(20, 120), pick_limit(5, 80));
        repeat ($urandom_range(1, 4))
        begin
            roll = $urandom_range(0, 9);
            send_frame(roll < 7 ? PAINT_DARK : (roll < 9 ? PAINT_NOISE : PAINT_FAINT));
        end
        settle();
    endtask

    // Stop partway into an image, then shrink the geometry so the stored position overshoots.
    task automatic mid_image_phase();
        int unsigned w0;
        int unsigned h0;
        int unsigned n;
        bit          ended;
        w0 = $urandom_range(20, 60);
        h0 = $urandom_range(3, 8);
        write_config(8'(w0), 8'(h0), 8'd30, 8'd60, 8'd30);
        n = $urandom_range(w0 / 2, w0 * 2);
        repeat (n) send_pixel(make_pixel(PAINT_DARK), ended);
        settle();
        write_config(8'($urandom_range(1, w0 / 2)), 8'($urandom_range(1, h0)),
                     8'd30, 8'd60, 8'd30);
        send_frame(PAINT_DARK);
        settle();
    endtask

    task automatic long_hold_phase();
        pix_gap_pct = 0;
        write_config(8'd1, 8'd1, 8'd0, 8'd60, 8'd30);
        hold_request = 1'b1;
        repeat (24) send_frame(PAINT_DARK);
        settle();
    endtask

    initial
    begin
        bit ended;
        int phase;
        board = new();
        pix_gap_pct   = 0;
        res_gap_pct   = 0;
        hold_request  = 1'b0;
        settings_used = 0;
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= REG_IMAGE_WIDTH;
        cfg_data     <= 8'd0;
        pix_ch.valid <= 1'b0;
        pix_ch.blue  <= 8'd0;
        pix_ch.green <= 8'd0;
        pix_ch.red   <= 8'd0;
        pix_ch.alpha <= 8'd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-pixel images: transparent, black, white, saturated colors
        write_config(8'd1, 8'd1, 8'd0, 8'd255, 8'd255);
        send_pixel(pixel_t'{8'd0, 8'd0, 8'd0, 8'd0}, ended);
        send_pixel(pixel_t'{8'd0, 8'd0, 8'd0, 8'd255}, ended);
        send_pixel(pixel_t'{8'd255, 8'd255, 8'd255, 8'd255}, ended);
        send_pixel(pixel_t'{8'd0, 8'd0, 8'd255, 8'd255}, ended);
        send_pixel(pixel_t'{8'd255, 8'd0, 8'd0, 8'd1}, ended);
        send_pixel(pixel_t'{8'd0, 8'd255, 8'd0, 8'd128}, ended);
        settle();
        // zero sides act as one; floor at top rejects everything but full alpha
        write_config(8'd0, 8'd0, 8'd255, 8'd0, 8'd0);
        send_pixel(pixel_t'{8'd10, 8'd10, 8'd10, 8'd254}, ended);
        send_pixel(pixel_t'{8'd10, 8'd10, 8'd10, 8'd255}, ended);
        settle();
        write_config(8'd3, 8'd2, RST_ALPHA_FLOOR, RST_LUMA_LIMIT, RST_CHROMA_LIMIT);
        send_pixel(pixel_t'{8'd20, 8'd22, 8'd25, 8'd255}, ended);
        send_pixel(pixel_t'{8'd30, 8'd30, 8'd30, 8'd39}, ended);
        send_pixel(pixel_t'{8'd5, 8'd8, 8'd12, 8'd40}, ended);
        send_pixel(pixel_t'{8'd200, 8'd190, 8'd180, 8'd0}, ended);
        send_pixel(pixel_t'{8'd40, 8'd45, 8'd44, 8'd200}, ended);
        send_pixel(pixel_t'{8'd15, 8'd15, 8'd60, 8'd255}, ended);
        settle();
        // floor zero: alpha zero samples add nothing
        write_config(8'd2, 8'd2, 8'd0, 8'd60, 8'd30);
        send_pixel(pixel_t'{8'd255, 8'd255, 8'd255, 8'd0}, ended);
        send_pixel(pixel_t'{8'd12, 8'd14, 8'd16, 8'd200}, ended);
        send_pixel(pixel_t'{8'd0, 8'd0, 8'd255, 8'd0}, ended);
        send_pixel(pixel_t'{8'd255, 8'd0, 8'd0, 8'd0}, ended);
        settle();

        // few large geometries, including oversized registers and coarse grid steps
        pix_gap_pct = 10;
        res_gap_pct = 10;
        write_config(8'd255, 8'd1, 8'd0, 8'd255, 8'd255);
        send_frame(PAINT_NOISE);
        settle();
        write_config(8'd1, 8'd200, 8'd128, 8'd90, 8'd40);
        send_frame(PAINT_DARK);
        settle();
        write_config(8'd100, 8'd2, 8'd40, 8'd70, 8'd35);
        send_frame(PAINT_DARK);
        settle();
        write_config(8'd33, 8'd3, 8'd40, 8'd70, 8'd35);
        send_frame(PAINT_DARK);
        settle();

        phase = 0;
        while (board.pixels < ITEM_TARGET)
        begin
            if (board.pixels > QUIET_AFTER)
            begin
                pix_gap_pct = 0;
                res_gap_pct = 0;
            end
            else
            begin
                pix_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
                res_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            end
            if (phase == 4)
                long_hold_phase();
            else if (phase % 15 == 7)
                mid_image_phase();
            else
                random_phase();
            phase++;
        end

        settle();
        $display("Checked %0d image verdicts from %0d pixels over %0d register settings",
                 board.frames, board.pixels, settings_used);
        $display("%0d verdicts near-black, %0d with no opaque sample",
                 board.dark_frames, board.empty_frames);
        if (board.errors == 0 && board.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

/* sim.f */
+incdir+rtl
rtl/nblc_pkg.sv
rtl/nblc_if.sv
rtl/nblc_front.sv
rtl/nblc_queue.sv
rtl/nblc_back.sv
rtl/near_black_logo_classifier.sv
dv/tb_near_black_logo_classifier.sv
